// File: rtl/core/key_debounce_press_classifier_assert.svh
// Assertion macros used by the port-level checker of the key debounce classifier.
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KDPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/kdpc_pkg.sv
// Shared types, codes and constants of the key debounce press classifier.
`default_nettype none

package kdpc_pkg;

    localparam int CODED_KEYS = 6;

    localparam logic [2:0] NO_KEY = 3'd6;

    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_LONG     = 2'd1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [15:0] LONG_RESET     = 16'd1000;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_SHORT   = 3'd2,
        EV_LONG    = 3'd3,
        EV_RELEASE = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [15:0] key_code(input logic [2:0] k);
        logic [15:0] code;
        unique case (k)
            3'd0:    code = 16'h0001;
            3'd1:    code = 16'hFDFF;
            3'd2:    code = 16'hFBFF;
            3'd3:    code = 16'hF7FF;
            3'd4:    code = 16'hEFFF;
            3'd5:    code = 16'hDFFF;
            default: code = 16'h0000;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/key_debounce_press_classifier.sv
// A request scans n keys (1 to min(NUM_KEYS, 6)), one key per cycle, and the scan stops
// at the first key with an event; the result then goes to the output register.
// A new request is taken only once the output load step of the previous one is done;
// a result waiting at the output stalls the next load only.
// Reset (synchronous, active low) clears all per-key state and restores the debounce
// time to 50 ms and the long-press time to 1000 ms.
`default_nettype none

module key_debounce_press_classifier #(
    parameter int NUM_KEYS = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_hw_reading,
    input  wire logic [31:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_kind,
    output logic [2:0]       o_key_index,
    output logic [5:0]       o_pressed_mask
);

    kdpc_pkg::t_dp_cmd  dp_cmd;
    kdpc_pkg::t_dp_stat dp_stat;

    kdpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_stall (o_stall)
    );

    kdpc_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_hw_reading   (i_hw_reading),
        .i_now_ms       (i_now_ms),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_event_kind   (o_event_kind),
        .o_key_index    (o_key_index),
        .o_pressed_mask (o_pressed_mask)
    );

endmodule

`default_nettype wire

// File: rtl/core/kdpc_ctrl.sv
// Controller state machine that sequences the key scan of one request.
`default_nettype none

module kdpc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire kdpc_pkg::t_dp_stat i_stat,
    output kdpc_pkg::t_dp_cmd       o_cmd,
    output logic                    o_stall
);

    kdpc_pkg::t_state r_state;
    kdpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kdpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kdpc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = kdpc_pkg::S_SCAN;
                end
            end
            kdpc_pkg::S_SCAN: begin
                if (i_stat.hit || i_stat.last) begin
                    n_state = kdpc_pkg::S_PUSH;
                end
            end
            kdpc_pkg::S_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = kdpc_pkg::S_IDLE;
                end
            end
            default: n_state = kdpc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            kdpc_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.load_in = i_valid;
            end
            kdpc_pkg::S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            kdpc_pkg::S_PUSH: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/kdpc_dp.sv
// Datapath with per-key debounce state, one-key step logic and output register.
`default_nettype none

module kdpc_dp #(
    parameter int NUM_KEYS = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kdpc_pkg::t_dp_cmd  i_cmd,
    output kdpc_pkg::t_dp_stat      o_stat,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic [15:0]        i_hw_reading,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [2:0]              o_event_kind,
    output logic [2:0]              o_key_index,
    output logic [5:0]              o_pressed_mask
);

    // Keys beyond the coded ones never read as pressed and keep their reset state.
    localparam int NK = (NUM_KEYS < kdpc_pkg::CODED_KEYS) ? NUM_KEYS : kdpc_pkg::CODED_KEYS;
    localparam int KW = (NK > 1) ? $clog2(NK) : 1;
    localparam logic [KW-1:0] LAST_K = KW'(NK - 1);

    logic [15:0]       r_debounce;
    logic [15:0]       r_long;
    logic [15:0]       r_word;
    logic [31:0]       r_now;
    logic [KW-1:0]     r_k;
    logic [NK-1:0]     r_raw;
    logic [NK-1:0]     r_held;
    logic [NK-1:0]     r_lr;
    logic [31:0]       r_ss [NK];
    logic [31:0]       r_ps [NK];
    kdpc_pkg::t_event  r_kind;
    logic [2:0]        r_key;
    logic              r_out_valid;
    kdpc_pkg::t_event  r_out_kind;
    logic [2:0]        r_out_key;
    logic [5:0]        r_out_mask;

    logic [2:0]        k3;
    logic              down;
    logic              held_k;
    logic              lr_k;
    logic [31:0]       n_ss;
    logic [31:0]       stable_dt;
    logic [31:0]       dur;
    logic              stable;
    logic              long_hit;
    kdpc_pkg::t_event  n_kind;
    logic [5:0]        held_mask;

    assign k3       = 3'(r_k);
    assign down     = (r_word == kdpc_pkg::key_code(k3));
    assign held_k   = r_held[r_k];
    assign lr_k     = r_lr[r_k];
    assign n_ss     = (down != r_raw[r_k]) ? r_now : r_ss[r_k];
    assign stable_dt = r_now - n_ss;
    assign dur      = r_now - r_ps[r_k];
    assign stable   = (stable_dt > {16'd0, r_debounce});
    assign long_hit = (dur >= {16'd0, r_long});

    always_comb begin
        n_kind = kdpc_pkg::EV_NONE;
        priority if (!stable) begin
            n_kind = kdpc_pkg::EV_NONE;
        end else if (down && !held_k) begin
            n_kind = kdpc_pkg::EV_PRESS;
        end else if (!down && held_k) begin
            n_kind = (lr_k || long_hit) ? kdpc_pkg::EV_RELEASE : kdpc_pkg::EV_SHORT;
        end else if (down && held_k && !lr_k && long_hit) begin
            n_kind = kdpc_pkg::EV_LONG;
        end else begin
            n_kind = kdpc_pkg::EV_NONE;
        end
    end

    always_comb begin
        held_mask = '0;
        held_mask[NK-1:0] = r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kdpc_pkg::DEBOUNCE_RESET;
            r_long     <= kdpc_pkg::LONG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == kdpc_pkg::CFG_DEBOUNCE) begin
                r_debounce <= i_cfg_data;
            end else if (i_cfg_index == kdpc_pkg::CFG_LONG) begin
                r_long <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_word <= i_hw_reading;
            r_now  <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_raw  <= '0;
            r_held <= '0;
            r_lr   <= '0;
            r_kind <= kdpc_pkg::EV_NONE;
            r_key  <= kdpc_pkg::NO_KEY;
            for (int i = 0; i < NK; i++) begin
                r_ss[i] <= '0;
                r_ps[i] <= '0;
            end
        end else if (i_cmd.load_in) begin
            r_k    <= '0;
            r_kind <= kdpc_pkg::EV_NONE;
            r_key  <= kdpc_pkg::NO_KEY;
        end else if (i_cmd.step) begin
            r_raw[r_k] <= down;
            r_ss[r_k]  <= n_ss;
            r_kind     <= n_kind;
            r_key      <= (n_kind != kdpc_pkg::EV_NONE) ? k3 : kdpc_pkg::NO_KEY;
            if (r_k != LAST_K) begin
                r_k <= r_k + 1'b1;
            end
            unique case (n_kind)
                kdpc_pkg::EV_PRESS: begin
                    r_held[r_k] <= 1'b1;
                    r_ps[r_k]   <= r_now;
                    r_lr[r_k]   <= 1'b0;
                end
                kdpc_pkg::EV_SHORT, kdpc_pkg::EV_RELEASE: begin
                    r_held[r_k] <= 1'b0;
                end
                kdpc_pkg::EV_LONG: begin
                    r_lr[r_k] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind <= r_kind;
            r_out_key  <= r_key;
            r_out_mask <= held_mask;
        end
    end

    assign o_stat.hit      = (n_kind != kdpc_pkg::EV_NONE);
    assign o_stat.last     = (r_k == LAST_K);
    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_key_index    = r_out_key;
    assign o_pressed_mask = r_out_mask;

endmodule

`default_nettype wire

// File: rtl/core/kdpc_chk.sv
// Port-level checker of the key debounce press classifier, bound to the top level.
`default_nettype none

`include "key_debounce_press_classifier_assert.svh"

module kdpc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_event_kind,
    input wire logic [2:0]  o_key_index,
    input wire logic [5:0]  o_pressed_mask
);

    `KDPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_event_kind) && $stable(o_key_index) && $stable(o_pressed_mask),
        "stalled result changed or dropped")

    `KDPC_ASSERT_IMP(a_none_no_key, i_clk, i_rst_n, o_valid,
        (o_event_kind == kdpc_pkg::EV_NONE) == (o_key_index == kdpc_pkg::NO_KEY),
        "event kind and key index disagree")

    `KDPC_ASSERT_IMP(a_down_mask, i_clk, i_rst_n,
        o_valid && (o_key_index < kdpc_pkg::NO_KEY) &&
        (o_event_kind == kdpc_pkg::EV_PRESS || o_event_kind == kdpc_pkg::EV_LONG),
        o_pressed_mask[o_key_index], "pressed key missing from mask")

    `KDPC_ASSERT_IMP(a_up_mask, i_clk, i_rst_n,
        o_valid && (o_key_index < kdpc_pkg::NO_KEY) &&
        (o_event_kind == kdpc_pkg::EV_SHORT || o_event_kind == kdpc_pkg::EV_RELEASE),
        !o_pressed_mask[o_key_index], "released key still in mask")

    `KDPC_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall,
        "request taken while the previous one is still scanning")

endmodule

bind key_debounce_press_classifier kdpc_chk u_kdpc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_event_kind   (o_event_kind),
    .o_key_index    (o_key_index),
    .o_pressed_mask (o_pressed_mask)
);

`default_nettype wire

// File: tb/key_debounce_press_classifier_checker.sv
// Checker for the key debounce press classifier: predicts every result and compares it.
`timescale 1ns / 1ps

module key_debounce_press_classifier_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic [15:0] i_req_hw_reading,
    input  wire logic [31:0] i_req_now_ms,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_stall,
    input  wire logic [2:0]  i_rsp_event_kind,
    input  wire logic [2:0]  i_rsp_key_index,
    input  wire logic [5:0]  i_rsp_pressed_mask,
    output int               o_pending,
    output int               o_checked,
    output int               o_mismatches
);

    localparam logic [95:0] KEY_CODE_TABLE = {
        16'hDFFF, 16'hEFFF, 16'hF7FF, 16'hFBFF, 16'hFDFF, 16'h0001
    };

    typedef struct packed {
        kdpc_pkg::t_event kind;
        logic [2:0]       key;
        logic [5:0]       mask;
    } t_poll_result;

    logic [15:0]  dbnc_ms;
    logic [15:0]  long_ms;
    logic [5:0]   raw_down;
    logic [31:0]  settle_stamp [0:5];
    logic [5:0]   key_held;
    logic [31:0]  hold_start [0:5];
    logic [5:0]   long_sent;
    t_poll_result expected_results [$];
    t_poll_result want;
    int           checked_count;
    int           mismatch_count;

    initial begin
        o_pending = 0;
        o_checked = 0;
        o_mismatches = 0;
        checked_count = 0;
        mismatch_count = 0;
    end

    function automatic t_poll_result classify_poll(input logic [15:0] word,
                                                   input logic [31:0] now);
        t_poll_result r;
        logic         down;
        logic [31:0]  quiet;
        logic [31:0]  dur;
        r.kind = kdpc_pkg::EV_NONE;
        r.key = kdpc_pkg::NO_KEY;
        for (int k = 0; k < kdpc_pkg::CODED_KEYS && r.kind == kdpc_pkg::EV_NONE; k++) begin
            down = (word == KEY_CODE_TABLE[k*16 +: 16]);
            if (down != raw_down[k]) begin
                settle_stamp[k] = now;
            end
            raw_down[k] = down;
            quiet = now - settle_stamp[k];
            if (quiet > {16'd0, dbnc_ms}) begin
                dur = now - hold_start[k];
                if (down && !key_held[k]) begin
                    key_held[k] = 1'b1;
                    hold_start[k] = now;
                    long_sent[k] = 1'b0;
                    r.kind = kdpc_pkg::EV_PRESS;
                    r.key = 3'(k);
                end else if (!down && key_held[k]) begin
                    key_held[k] = 1'b0;
                    if (long_sent[k] || dur >= {16'd0, long_ms}) begin
                        r.kind = kdpc_pkg::EV_RELEASE;
                    end else begin
                        r.kind = kdpc_pkg::EV_SHORT;
                    end
                    r.key = 3'(k);
                end else if (down && key_held[k] && !long_sent[k] &&
                             dur >= {16'd0, long_ms}) begin
                    long_sent[k] = 1'b1;
                    r.kind = kdpc_pkg::EV_LONG;
                    r.key = 3'(k);
                end
            end
        end
        r.mask = key_held;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dbnc_ms = kdpc_pkg::DEBOUNCE_RESET;
            long_ms = kdpc_pkg::LONG_RESET;
            raw_down = '0;
            key_held = '0;
            long_sent = '0;
            for (int k = 0; k < kdpc_pkg::CODED_KEYS; k++) begin
                settle_stamp[k] = '0;
                hold_start[k] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (i_rsp_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind,
                               i_rsp_event_kind);
                        mismatch_count++;
                    end
                    if (i_rsp_key_index !== want.key) begin
                        $error("key_index: expected %0d, got %0d", want.key,
                               i_rsp_key_index);
                        mismatch_count++;
                    end
                    if (i_rsp_pressed_mask !== want.mask) begin
                        $error("pressed_mask: expected 0x%02h, got 0x%02h", want.mask,
                               i_rsp_pressed_mask);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kdpc_pkg::CFG_DEBOUNCE: dbnc_ms = i_cfg_data;
                    kdpc_pkg::CFG_LONG:     long_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results.push_back(classify_poll(i_req_hw_reading, i_req_now_ms));
            end
        end
        o_pending <= expected_results.size();
        o_checked <= checked_count;
        o_mismatches <= mismatch_count;
    end

endmodule

// File: tb/key_debounce_press_classifier_tb.sv
// Top of the key debounce press classifier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module key_debounce_press_classifier_tb;

    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = kdpc_pkg::CFG_DEBOUNCE;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [15:0] i_hw_reading = '0;
    logic [31:0] i_now_ms = '0;
    logic        i_stall = 1'b0;
    wire logic        o_stall;
    wire logic        o_valid;
    wire logic [2:0]  o_event_kind;
    wire logic [2:0]  o_key_index;
    wire logic [5:0]  o_pressed_mask;
    int pending;
    int checked;
    int mismatches;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          polls_sent = 0;
    int          settings_used = 1;
    logic [31:0] clock_ms = '0;
    logic [15:0] cur_dbnc = kdpc_pkg::DEBOUNCE_RESET;
    logic [15:0] cur_long = kdpc_pkg::LONG_RESET;

    key_debounce_press_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_hw_reading   (i_hw_reading),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_key_index    (o_key_index),
        .o_pressed_mask (o_pressed_mask)
    );

    key_debounce_press_classifier_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_valid        (i_valid),
        .i_req_stall        (o_stall),
        .i_req_hw_reading   (i_hw_reading),
        .i_req_now_ms       (i_now_ms),
        .i_rsp_valid        (o_valid),
        .i_rsp_stall        (i_stall),
        .i_rsp_event_kind   (o_event_kind),
        .i_rsp_key_index    (o_key_index),
        .i_rsp_pressed_mask (o_pressed_mask),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_mismatches       (mismatches)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("key_debounce_press_classifier_tb failed");
        $finish;
    end

    // The receiver stalls at random, or holds off for a counted stretch on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_poll(input logic [15:0] word, input logic [31:0] stamp);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_hw_reading <= word;
        i_now_ms <= stamp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        polls_sent++;
    endtask

    task automatic step_poll(input logic [15:0] word, input int span);
        clock_ms = clock_ms + $urandom_range(span, 1);
        send_poll(word, clock_ms);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_timing(input logic [15:0] dbnc, input logic [15:0] lp_ms);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SPARE_A;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_index <= kdpc_pkg::CFG_DEBOUNCE;
        i_cfg_data <= dbnc;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE_B;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_index <= kdpc_pkg::CFG_LONG;
        i_cfg_data <= lp_ms;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_dbnc = dbnc;
        cur_long = lp_ms;
        settings_used++;
    endtask

    // Mostly clean press, hold and release sequences, with key changes and noise mixed in.
    task automatic run_polls(input int count);
        int          stop;
        int          span;
        int          choice;
        int          n;
        logic [2:0]  k;
        logic [15:0] rest_word;
        stop = polls_sent + count;
        span = (int'(cur_dbnc) + int'(cur_long)) / 6 + 4;
        while (polls_sent < stop) begin
            choice = $urandom_range(99);
            k = 3'($urandom_range(kdpc_pkg::CODED_KEYS - 1));
            case ($urandom_range(2))
                0: rest_word = 16'hFFFF;
                1: rest_word = 16'h0000;
                default: rest_word = 16'($urandom);
            endcase
            if (choice < 85) begin
                n = $urandom_range(14, 2);
                repeat (n) step_poll(kdpc_pkg::key_code(k), span);
                if (choice >= 70) begin
                    k = 3'($urandom_range(kdpc_pkg::CODED_KEYS - 1));
                    n = $urandom_range(10, 1);
                    repeat (n) step_poll(kdpc_pkg::key_code(k), span);
                end
                n = $urandom_range(8, 2);
                repeat (n) step_poll(rest_word, span);
            end else begin
                n = $urandom_range(6, 1);
                repeat (n) begin
                    if ($urandom_range(3) == 0) begin
                        clock_ms = $urandom;
                    end
                    if ($urandom_range(3) == 0) begin
                        step_poll(kdpc_pkg::key_code(k), span);
                    end else begin
                        step_poll(16'($urandom), span);
                    end
                end
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] dbnc, input logic [15:0] lp_ms,
                             input int idle, input int stall, input int hold, input int count);
        drain();
        program_timing(dbnc, lp_ms);
        send_idle_pct = idle;
        stall_pct = stall;
        hold_cycles = hold;
        run_polls(count);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: 50 ms debounce, 1000 ms long press.
        send_poll(16'h0000, 32'd0);
        send_poll(16'hFFFF, 32'd5);
        send_poll(kdpc_pkg::key_code(3'd0), 32'd10);
        send_poll(kdpc_pkg::key_code(3'd0), 32'd60);
        send_poll(kdpc_pkg::key_code(3'd0), 32'd61);
        send_poll(kdpc_pkg::key_code(3'd0), 32'd1060);
        send_poll(kdpc_pkg::key_code(3'd0), 32'd1061);
        send_poll(kdpc_pkg::key_code(3'd0), 32'd1500);
        send_poll(16'hFFFF, 32'd1501);
        send_poll(16'hFFFF, 32'd1600);
        send_poll(kdpc_pkg::key_code(3'd5), 32'd2000);
        send_poll(kdpc_pkg::key_code(3'd5), 32'd2051);
        send_poll(16'hFFFF, 32'd2100);
        send_poll(16'hFFFF, 32'd2151);
        // Held past the long time, but released before the long press was reported.
        send_poll(kdpc_pkg::key_code(3'd2), 32'd3000);
        send_poll(kdpc_pkg::key_code(3'd2), 32'd3051);
        send_poll(16'h0000, 32'd4100);
        send_poll(16'h0000, 32'd4200);
        // A release of one key ends the scan before the next key is looked at.
        send_poll(kdpc_pkg::key_code(3'd1), 32'd5000);
        send_poll(kdpc_pkg::key_code(3'd1), 32'd5100);
        send_poll(kdpc_pkg::key_code(3'd3), 32'd5101);
        send_poll(kdpc_pkg::key_code(3'd3), 32'd5200);
        send_poll(kdpc_pkg::key_code(3'd3), 32'd5201);
        // Time wraps through zero.
        send_poll(kdpc_pkg::key_code(3'd4), 32'hFFFF_FFFF);
        send_poll(kdpc_pkg::key_code(3'd4), 32'h0000_0040);
        send_poll(kdpc_pkg::key_code(3'd4), 32'h0000_0060);
        clock_ms = 32'h0000_0100;

        run_phase(16'd0, 16'd0, 0, 0, 0, 290);
        run_phase(16'hFFFF, 16'hFFFF, 65, 0, 0, 290);
        run_phase(16'd20, 16'd300, 0, 65, 0, 290);
        run_phase(16'($urandom_range(120)), 16'($urandom_range(1500)), 32, 32, 0, 290);
        run_phase(16'd5, 16'hFFFF, 0, 20, 400, 290);
        clock_ms = 32'hFFFF_C000;
        run_phase(kdpc_pkg::DEBOUNCE_RESET, kdpc_pkg::LONG_RESET, 32, 32, 0, 290);
        drain();

        $display("Summary: %0d polls sent and %0d results checked under %0d timing settings,",
                 polls_sent, checked, settings_used);
        $display("Summary: with free flow, sender gaps, receiver stalls, both, and a long hold-off.");
        if (mismatches == 0) begin
            $display("key_debounce_press_classifier_tb passed");
        end else begin
            $display("key_debounce_press_classifier_tb failed");
        end
        $finish;
    end

endmodule
